### rtl/nfba_pkg.sv
// Shared constants, types and codes for the next-fit block allocator.
`timescale 1ns / 1ps

package nfba_pkg;

  // Table geometry.
  localparam int MAX_BLOCKS = 64;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // Fixed field widths of the ports.
  localparam int PIDX_W = 6;
  localparam int AMT_W  = 16;
  localparam int TOT_W  = 22;
  localparam int CFG_W  = 7;

  // Width used for comparing a block's free space against a request.
  localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

  localparam logic [CMP_W-1:0] SIZE_MAX = CMP_W'((64'(1) << SIZE_BITS) - 64'(1));
  localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(MAX_BLOCKS);

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_ALLOC = 1'b1
  } req_kind_t;

  typedef enum logic {
    FOP_LOAD,
    FOP_ALLOC
  } fit_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN
  } state_t;

  // Result of the shared compare and update unit.
  typedef struct packed {
    logic                 fit;
    logic [SIZE_BITS-1:0] remain;
    logic [TOT_W-1:0]     total_next;
  } fit_res_t;

endpackage

### rtl/nfba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module nfba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/nfba_fit_unit.sv
// Shared compare and subtract unit: fit test, remaining space and total update.
`timescale 1ns / 1ps

module nfba_fit_unit
  import nfba_pkg::*;
(
  input  fit_op_t              op,
  input  logic [SIZE_BITS-1:0] free,
  input  logic [AMT_W-1:0]     amt,
  input  logic                 used,
  input  logic [TOT_W-1:0]     total,
  output fit_res_t             res
);

  logic [CMP_W-1:0] free_x;
  logic [CMP_W-1:0] amt_x;
  logic [CMP_W-1:0] diff;

  assign free_x = CMP_W'(free);
  assign amt_x  = CMP_W'(amt);
  assign diff   = free_x - amt_x;

  always_comb begin
    res.fit        = (free_x >= amt_x);
    res.remain     = SIZE_BITS'(diff);
    res.total_next = total;
    unique case (op)
      FOP_LOAD: begin
        // A used block's space leaves the total before it is reloaded.
        if (used) begin
          res.total_next = total - TOT_W'(free);
        end
      end
      FOP_ALLOC: begin
        if (amt != '0) begin
          if (used) begin
            res.total_next = total - TOT_W'(amt);
          end else begin
            res.total_next = total + TOT_W'(diff);
          end
        end
      end
      default: res.total_next = total;
    endcase
  end

endmodule

### rtl/next_fit_block_allocator_unit.sv
// Top level of the next-fit block allocator: sequencer, block table and result register.
`timescale 1ns / 1ps

// Next-fit allocator over a table of up to 64 blocks. For a load, the transfer
// cycle issues the read of the old entry, and ST_LOAD then rewrites it and loads
// the result register. For an allocation, the transfer cycle issues the read of
// the first block, and ST_SCAN then examines m blocks, m being 1 to block_count
// clamped into 1..64. The block table is one RAM with a single registered read
// port, and the scan reads one block per cycle through the shared compare unit;
// the result register is loaded once a block fits or the last block misses. A
// stalled result holds the block in the last cycle of its item until the output
// register frees. The input is stalled from the transfer of an item until its
// result is loaded into the output register; a waiting result does not stall
// the next input transfer. block_count may be written at any time the block is
// idle; the write port is always ready. Reading a block that was never loaded
// gives an unpredictable size.
module next_fit_block_allocator_unit
  import nfba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [PIDX_W-1:0] block_index,
  input  logic [AMT_W-1:0]  amount,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              granted,
  output logic [PIDX_W-1:0] block_granted,
  output logic [TOT_W-1:0]  total_fragmentation,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  state_t state, state_next;

  logic [CFG_W-1:0]      block_count;
  logic [IDX_W-1:0]      scan_pointer;
  logic [TOT_W-1:0]      total;
  logic [MAX_BLOCKS-1:0] used_mark;
  logic [IDX_W-1:0]      cur;
  logic [IDX_W-1:0]      start_ptr;
  logic [CNT_W-1:0]      examined;
  logic [AMT_W-1:0]      amt_q;
  logic                  load_ok;
  logic [SIZE_BITS-1:0]  load_val_q;

  logic [CNT_W-1:0]     eff_count;
  logic [IDX_W-1:0]     start;
  logic [IDX_W-1:0]     cur_next;
  logic [CNT_W:0]       cur_inc;
  logic                 last;
  logic                 out_free;
  logic                 in_load_ok;
  logic [CMP_W-1:0]     amount_x;
  logic [SIZE_BITS-1:0] load_val;

  logic                 rd_we;
  logic [IDX_W-1:0]     rd_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [SIZE_BITS-1:0] rd_data;

  fit_op_t  fop;
  fit_res_t fres;

  logic do_accept;
  logic do_load;
  logic do_hit;
  logic do_fail;
  logic do_advance;

  assign cfg_ready = 1'b1;

  // Clamp the configured count into 1..MAX_BLOCKS.
  always_comb begin
    if (block_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(block_count) > MAX_BLOCKS) begin
      eff_count = CNT_W'(MAX_BLOCKS);
    end else begin
      eff_count = CNT_W'(block_count);
    end
  end

  assign start      = (CNT_W'(scan_pointer) >= eff_count) ? '0 : scan_pointer;
  assign cur_inc    = (CNT_W + 1)'(cur) + (CNT_W + 1)'(1);
  assign cur_next   = (cur_inc >= (CNT_W + 1)'(eff_count)) ? '0 : IDX_W'(cur_inc);
  assign last       = (examined == eff_count - CNT_W'(1));
  assign out_free   = !out_valid || !out_stall;
  assign in_load_ok = (32'(block_index) < MAX_BLOCKS);
  assign amount_x   = CMP_W'(amount);
  assign load_val   = (amount_x > SIZE_MAX) ? SIZE_BITS'(SIZE_MAX) : SIZE_BITS'(amount_x);

  assign fop = (state == ST_LOAD) ? FOP_LOAD : FOP_ALLOC;

  nfba_fit_unit u_fit (
    .op    (fop),
    .free  (rd_data),
    .amt   (amt_q),
    .used  (used_mark[cur] && (load_ok || state == ST_SCAN)),
    .total (total),
    .res   (fres)
  );

  nfba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (rd_we),
    .waddr (cur),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    rd_addr    = cur;
    rd_we      = 1'b0;
    wr_data    = fres.remain;
    do_accept  = 1'b0;
    do_load    = 1'b0;
    do_hit     = 1'b0;
    do_fail    = 1'b0;
    do_advance = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          do_accept = 1'b1;
          if (req_type == REQ_LOAD) begin
            rd_addr    = IDX_W'(block_index);
            state_next = ST_LOAD;
          end else begin
            rd_addr    = start;
            state_next = ST_SCAN;
          end
        end
      end
      ST_LOAD: begin
        wr_data = load_val_q;
        if (out_free) begin
          do_load    = 1'b1;
          rd_we      = load_ok;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (fres.fit) begin
          if (out_free) begin
            do_hit     = 1'b1;
            rd_we      = (amt_q != '0);
            state_next = ST_IDLE;
          end
        end else if (last) begin
          if (out_free) begin
            do_fail    = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          do_advance = 1'b1;
          rd_addr    = cur_next;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Item context captured at the input transfer.
  always_ff @(posedge clk) begin
    if (do_accept) begin
      amt_q      <= amount;
      load_val_q <= load_val;
      load_ok    <= in_load_ok;
      start_ptr  <= start;
      cur        <= (req_type == REQ_LOAD) ? IDX_W'(block_index) : start;
    end else if (do_advance) begin
      cur <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_accept) begin
      examined <= '0;
    end else if (do_advance) begin
      examined <= examined + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count  <= COUNT_RESET;
      scan_pointer <= '0;
      total        <= '0;
      used_mark    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        block_count <= cfg_data;
      end
      if (do_load) begin
        scan_pointer <= '0;
        total        <= fres.total_next;
        if (load_ok) begin
          used_mark[cur] <= 1'b0;
        end
      end
      if (do_hit) begin
        scan_pointer <= cur;
        total        <= fres.total_next;
        if (amt_q != '0) begin
          used_mark[cur] <= 1'b1;
        end
      end
      if (do_fail) begin
        scan_pointer <= start_ptr;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_load || do_hit || do_fail) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load || do_fail) begin
      granted             <= 1'b0;
      block_granted       <= '0;
      total_fragmentation <= do_load ? fres.total_next : total;
    end else if (do_hit) begin
      granted             <= 1'b1;
      block_granted       <= PIDX_W'(cur);
      total_fragmentation <= fres.total_next;
    end
  end

endmodule

### rtl/nfba_checker.sv
// Port-level checker for the next-fit block allocator and its bind.
`timescale 1ns / 1ps

module nfba_checker
  import nfba_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              granted,
  input logic [PIDX_W-1:0] block_granted,
  input logic [TOT_W-1:0]  total_fragmentation
);

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  // A new result only appears after an item was in progress.
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an item in progress");

  a_no_grant_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (block_granted == '0))
    else $error("block index reported without a grant");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(granted) &&
      $stable(block_granted) && $stable(total_fragmentation)))
    else $error("stalled result changed");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

endmodule

bind next_fit_block_allocator_unit nfba_checker u_nfba_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .granted             (granted),
  .block_granted       (block_granted),
  .total_fragmentation (total_fragmentation)
);

### sim/nfba_checker.sv
// Checker for the next-fit allocator: mirrors the block table and compares each result.
`timescale 1ns / 1ps

module nfba_scoreboard
  import nfba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              req_type,
  input  logic [PIDX_W-1:0] block_index,
  input  logic [AMT_W-1:0]  amount,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              granted,
  input  logic [PIDX_W-1:0] block_granted,
  input  logic [TOT_W-1:0]  total_fragmentation,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                error_count,
  output int                outstanding
);

  typedef struct {
    logic              granted;
    logic [PIDX_W-1:0] block;
    logic [TOT_W-1:0]  total;
  } alloc_outcome_t;

  logic [SIZE_BITS-1:0] free_left [MAX_BLOCKS];
  bit                   in_use    [MAX_BLOCKS];
  int                   scan_at;
  longint               frag_sum;
  logic [CFG_W-1:0]     count_reg;
  alloc_outcome_t       awaited_outcomes [$];
  int                   fails = 0;

  assign error_count = fails;

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    fails++;
  endtask

  // Applies one request to the mirrored table and returns the result it must produce.
  function automatic alloc_outcome_t next_fit(req_kind_t kind, int idx,
                                              logic [AMT_W-1:0] amt);
    alloc_outcome_t res;
    int span;
    int p;
    int k;
    bit hit;
    res.granted = 1'b0;
    res.block = '0;
    hit = 1'b0;
    if (kind == REQ_LOAD) begin
      if (in_use[idx]) frag_sum -= free_left[idx];
      in_use[idx] = 1'b0;
      free_left[idx] = amt;
      scan_at = 0;
    end else begin
      span = (count_reg == 0) ? 1 : ((count_reg > MAX_BLOCKS) ? MAX_BLOCKS : count_reg);
      p = (scan_at >= span) ? 0 : scan_at;
      for (k = 0; k < span && !hit; k++) begin
        if (free_left[p] >= amt) begin
          hit = 1'b1;
          res.granted = 1'b1;
          res.block = p[PIDX_W-1:0];
          // A zero request is granted in place and leaves the block untouched.
          if (amt != 0) begin
            if (in_use[p]) frag_sum -= amt;
            else frag_sum += free_left[p] - amt;
            free_left[p] -= amt;
            in_use[p] = 1'b1;
          end
        end else begin
          p = (p + 1 >= span) ? 0 : p + 1;
        end
      end
      // On a miss the scan has come full circle back to where it started.
      scan_at = p;
    end
    res.total = frag_sum[TOT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    alloc_outcome_t want;
    if (rst) begin
      foreach (in_use[i]) begin
        in_use[i] = 1'b0;
        free_left[i] = '0;
      end
      scan_at = 0;
      frag_sum = 0;
      count_reg = COUNT_RESET;
      awaited_outcomes.delete();
    end else begin
      // A result never belongs to an input taken at the same edge, so retire first.
      if (out_valid && !out_stall) begin
        if (awaited_outcomes.size() == 0) begin
          flag_mismatch("unexpected result", 32'(granted), 32'(0));
        end else begin
          want = awaited_outcomes.pop_front();
          if (granted !== want.granted)
            flag_mismatch("granted", 32'(granted), 32'(want.granted));
          if (block_granted !== want.block)
            flag_mismatch("block_granted", 32'(block_granted), 32'(want.block));
          if (total_fragmentation !== want.total)
            flag_mismatch("total_fragmentation", 32'(total_fragmentation),
                          32'(want.total));
        end
      end
      if (cfg_valid && cfg_ready) count_reg = cfg_data;
      if (in_valid && !in_stall)
        awaited_outcomes.insert(awaited_outcomes.size(),
                                next_fit(req_kind_t'(req_type), int'(block_index), amount));
    end
    outstanding <= awaited_outcomes.size();
  end

endmodule

### sim/testbench.sv
// Top of the allocator testbench: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import nfba_pkg::*;

  localparam int RUN_LIMIT   = 1_000_000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 100;
  localparam int TAIL_CYCLES = 80;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              req_type = 1'b0;
  logic [PIDX_W-1:0] block_index = '0;
  logic [AMT_W-1:0]  amount = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              granted;
  logic [PIDX_W-1:0] block_granted;
  logic [TOT_W-1:0]  total_fragmentation;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;

  int error_count;
  int outstanding;
  int cycles = 0;
  int live_count = MAX_BLOCKS;
  bit no_idle = 1'b0;
  bit loaded [MAX_BLOCKS];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  next_fit_block_allocator_unit dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .req_type            (req_type),
    .block_index         (block_index),
    .amount              (amount),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .granted             (granted),
    .block_granted       (block_granted),
    .total_fragmentation (total_fragmentation),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  nfba_scoreboard u_check (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .req_type            (req_type),
    .block_index         (block_index),
    .amount              (amount),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .granted             (granted),
    .block_granted       (block_granted),
    .total_fragmentation (total_fragmentation),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .error_count         (error_count),
    .outstanding         (outstanding)
  );

  // Presents one request after a random gap (none while no_idle is set) and returns at the edge of its transfer.
  task automatic send(req_kind_t kind, logic [PIDX_W-1:0] idx, logic [AMT_W-1:0] amt);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    block_index <= idx;
    amount      <= amt;
    if (kind == REQ_LOAD) loaded[idx] = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic ask(logic [AMT_W-1:0] amt);
    send(REQ_ALLOC, PIDX_W'($urandom), amt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_block_count(logic [CFG_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    live_count = (value == 0) ? 1 : ((value > MAX_BLOCKS) ? MAX_BLOCKS : value);
  endtask

  // Lowest block in the active range that was never loaded, or -1.
  function automatic int first_unloaded();
    int b;
    for (b = 0; b < live_count; b++) begin
      if (!loaded[b]) return b;
    end
    return -1;
  endfunction

  task automatic random_item();
    int hole;
    int pick;
    logic [PIDX_W-1:0] idx;
    logic [AMT_W-1:0]  amt;
    hole = first_unloaded();
    pick = $urandom_range(0, 99);
    idx = PIDX_W'($urandom);
    // An allocation may read every active block, so all of them get loaded first.
    if (hole >= 0 || pick < 25) begin
      if (hole >= 0) idx = PIDX_W'(hole);
      else if (pick < 20) idx = PIDX_W'($urandom_range(0, live_count - 1));
      case ($urandom_range(0, 9))
        0: amt = '1;
        1: amt = '0;
        2, 3, 4, 5: amt = AMT_W'($urandom_range(100, 4000));
        default: amt = AMT_W'($urandom);
      endcase
      send(REQ_LOAD, idx, amt);
    end else begin
      case ($urandom_range(0, 9))
        0: amt = '0;
        1: amt = '1;
        2, 3, 4, 5, 6: amt = AMT_W'($urandom_range(1, 600));
        7, 8: amt = AMT_W'($urandom_range(601, 8000));
        default: amt = AMT_W'($urandom);
      endcase
      send(REQ_ALLOC, idx, amt);
    end
  endtask

  // Receive side: a random hold before each result, with quiet stretches.
  initial begin
    int hold;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("next_fit_block_allocator_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int phase;
    int i;
    logic [CFG_W-1:0] setting;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Two blocks: fill, exhaust, reload used blocks and wrap the scan.
    set_block_count(2);
    send(REQ_LOAD, 6'd0, 16'hFFFF);
    send(REQ_LOAD, 6'd1, 16'h0000);
    ask(16'd0);
    ask(16'hFFFF);
    ask(16'd1);
    ask(16'd0);
    send(REQ_LOAD, 6'd0, 16'd1000);
    ask(16'd300);
    ask(16'd200);
    send(REQ_LOAD, 6'd1, 16'd800);
    ask(16'd600);
    ask(16'd150);
    ask(16'd100);
    send(REQ_LOAD, 6'd63, 16'hFFFF);
    ask(16'd600);
    ask(16'd0);
    ask(16'd380);
    ask(16'd40);
    // The pointer now sits on block 1; a count of zero acts as one, so it wraps.
    set_block_count(0);
    ask(16'd10);
    ask(16'd11);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: setting = 7'd127;
        1: setting = 7'd64;
        2: setting = 7'd1;
        3: setting = 7'd2;
        4: setting = 7'd65;
        5: setting = 7'd0;
        6: setting = 7'd3;
        default: setting = CFG_W'($urandom_range(1, 64));
      endcase
      set_block_count(setting);
      no_idle = ($urandom_range(0, 3) == 0);
      for (i = 0; i < PHASE_ITEMS; i++) random_item();
    end

    no_idle = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("next_fit_block_allocator_unit regression: pass");
    end else begin
      $display("next_fit_block_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/nfba_pkg.sv
rtl/nfba_ram.sv
rtl/nfba_fit_unit.sv
rtl/next_fit_block_allocator_unit.sv
rtl/nfba_checker.sv
sim/nfba_checker.sv
sim/testbench.sv
